/* rtl/pt32_pkg.sv */
package pt32_pkg;

   localparam int unsigned CAND_W      = 32;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned DIV_W       = 11;
   localparam int unsigned SQ_W        = 22;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned MM_STEPS    = 32;
   localparam int unsigned MM_CNT_W    = 5;

   localparam logic [CAND_W-1:0] TRIAL_LIMIT = 32'd1373653;
   localparam logic [CAND_W-1:0] PAIR_LIMIT  = 32'd9080191;
   localparam logic [DIV_W-1:0]  FIRST_DIV   = 11'd5;
   localparam logic [SQ_W-1:0]   FIRST_SQ    = 22'd25;

   typedef enum logic [2:0] {
      CLS_COMPOSITE,
      CLS_PRIME,
      CLS_TRIAL,
      CLS_MR_PAIR,
      CLS_MR_TRIPLE
   } cls_type;

   typedef struct packed {
      logic [CAND_W-1:0] candidate;
      cls_type           cls;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [CAND_W-1:0] x;
      logic [CAND_W-1:0] y;
      logic [CAND_W-1:0] m;
   } mm_req_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_TD_TEST,
      B_TD_WAIT,
      B_MR_SPLIT,
      B_POW_TEST,
      B_POW_MUL,
      B_POW_SQR,
      B_SQ_TEST,
      B_SQ_WAIT,
      B_FINISH
   } back_state_type;

   function automatic logic [CAND_W-1:0] base_of(input cls_type cls, input logic [1:0] idx);
      logic [CAND_W-1:0] b;
      b = 32'd2;
      if (cls == CLS_MR_PAIR) begin
         b = (idx == 2'd0) ? 32'd31 : 32'd73;
      end else begin
         case (idx)
            2'd0:    b = 32'd2;
            2'd1:    b = 32'd7;
            default: b = 32'd61;
         endcase
      end
      return b;
   endfunction

   function automatic logic is_last_base(input cls_type cls, input logic [1:0] idx);
      return (cls == CLS_MR_PAIR) ? (idx == 2'd1) : (idx == 2'd2);
   endfunction

endpackage

/* rtl/pt32_front.sv */
module pt32_front (
   input  logic [pt32_pkg::CAND_W-1:0] candidate,
   output pt32_pkg::entry_type          entry
);

   function automatic logic is_mult3(input logic [31:0] n);
      logic [5:0] s;
      logic [3:0] t;
      s = '0;
      for (int i = 0; i < 16; i++) begin
         s = s + 6'(n[2*i +: 2]);
      end
      t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
      if (t >= 4'd6) begin
         t = t - 4'd6;
      end
      if (t >= 4'd3) begin
         t = t - 4'd3;
      end
      return t == 4'd0;
   endfunction

   always_comb begin
      entry.candidate = candidate;
      if (candidate < 32'd2) begin
         entry.cls = pt32_pkg::CLS_COMPOSITE;
      end else if (!candidate[0]) begin
         entry.cls = (candidate == 32'd2) ? pt32_pkg::CLS_PRIME : pt32_pkg::CLS_COMPOSITE;
      end else if (is_mult3(candidate)) begin
         entry.cls = (candidate == 32'd3) ? pt32_pkg::CLS_PRIME : pt32_pkg::CLS_COMPOSITE;
      end else if (candidate < pt32_pkg::TRIAL_LIMIT) begin
         entry.cls = pt32_pkg::CLS_TRIAL;
      end else if (candidate < pt32_pkg::PAIR_LIMIT) begin
         entry.cls = pt32_pkg::CLS_MR_PAIR;
      end else begin
         entry.cls = pt32_pkg::CLS_MR_TRIPLE;
      end
   end

endmodule

/* rtl/pt32_queue.sv */
module pt32_queue #(
   parameter int unsigned DEPTH = pt32_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pt32_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output pt32_pkg::entry_type head,
   output logic                head_valid
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pt32_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/pt32_modmul.sv */
module pt32_modmul (
   input  logic                        clock,
   input  logic                        reset,
   input  pt32_pkg::mm_req_type        req,
   output logic                        done,
   output logic [pt32_pkg::CAND_W-1:0] result
);

   logic [31:0] x_ff, x_in;
   logic [31:0] y_ff, y_in;
   logic [31:0] m_ff, m_in;
   logic [31:0] r_ff, r_in;
   logic [pt32_pkg::MM_CNT_W-1:0] cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] t, m1, m2, red;

   assign done   = done_ff;
   assign result = r_ff;

   always_comb begin
      m1 = {2'b00, m_ff};
      m2 = {1'b0, m_ff, 1'b0};
      t  = {1'b0, r_ff, 1'b0} + (y_ff[31] ? {2'b00, x_ff} : 34'd0);
      if (t >= m2) begin
         red = t - m2;
      end else if (t >= m1) begin
         red = t - m1;
      end else begin
         red = t;
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         x_in    = req.x;
         y_in    = req.y;
         m_in    = req.m;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = red[31:0];
         y_in   = {y_ff[30:0], 1'b0};
         cnt_in = cnt_ff + pt32_pkg::MM_CNT_W'(1);
         if (cnt_ff == pt32_pkg::MM_CNT_W'(pt32_pkg::MM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      m_ff <= m_in;
      r_ff <= r_in;
   end

endmodule

/* rtl/pt32_back.sv */
module pt32_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pt32_pkg::entry_type         head,
   input  logic                        head_valid,
   output logic                        pop,
   output pt32_pkg::mm_req_type        mm_req,
   input  logic                        mm_done,
   input  logic [pt32_pkg::CAND_W-1:0] mm_result,
   output logic                        rsp_valid,
   output logic                        rsp_is_prime,
   input  logic                        rsp_stall
);

   localparam int unsigned DW = pt32_pkg::DIV_W;
   localparam int unsigned SW = pt32_pkg::SQ_W;

   pt32_pkg::back_state_type state_ff, state_in;
   pt32_pkg::cls_type        cls_ff, cls_in;
   logic [31:0]    n_ff, n_in;
   logic [DW-1:0]  div_ff, div_in;
   logic [SW-1:0]  sq_ff, sq_in;
   logic           side_ff, side_in;
   logic [31:0]    e_ff, e_in;
   logic [pt32_pkg::SHIFT_W-1:0] s_ff, s_in;
   logic [pt32_pkg::SHIFT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]    acc_ff, acc_in;
   logic [31:0]    b_ff, b_in;
   logic [31:0]    x_ff, x_in;
   logic [31:0]    y_ff, y_in;
   logic [1:0]     idx_ff, idx_in;
   logic           verdict_ff, verdict_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_is_prime_ff, rsp_is_prime_in;

   logic           out_free, sq_above, last_base, witness;
   logic [DW-1:0]  div_hi;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign sq_above     = 32'(sq_ff) > n_ff;
   assign last_base    = pt32_pkg::is_last_base(cls_ff, idx_ff);
   assign div_hi       = div_ff + DW'(2);
   assign witness      = (mm_result == 32'd1) && (x_ff != 32'd1) && (x_ff != n_ff - 32'd1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pt32_pkg::B_IDLE: begin
            if (head_valid) begin
               case (head.cls)
                  pt32_pkg::CLS_COMPOSITE: state_in = pt32_pkg::B_FINISH;
                  pt32_pkg::CLS_PRIME:     state_in = pt32_pkg::B_FINISH;
                  pt32_pkg::CLS_TRIAL:     state_in = pt32_pkg::B_TD_TEST;
                  default:                 state_in = pt32_pkg::B_MR_SPLIT;
               endcase
            end
         end
         pt32_pkg::B_TD_TEST: begin
            state_in = sq_above ? pt32_pkg::B_FINISH : pt32_pkg::B_TD_WAIT;
         end
         pt32_pkg::B_TD_WAIT: begin
            if (mm_done) begin
               if (mm_result == '0) begin
                  state_in = pt32_pkg::B_FINISH;
               end else if (side_ff) begin
                  state_in = pt32_pkg::B_TD_TEST;
               end
            end
         end
         pt32_pkg::B_MR_SPLIT: begin
            if (e_ff[0]) begin
               state_in = pt32_pkg::B_POW_TEST;
            end
         end
         pt32_pkg::B_POW_TEST: begin
            if (e_ff == '0) begin
               state_in = pt32_pkg::B_SQ_TEST;
            end else if (e_ff[0]) begin
               state_in = pt32_pkg::B_POW_MUL;
            end else begin
               state_in = pt32_pkg::B_POW_SQR;
            end
         end
         pt32_pkg::B_POW_MUL: begin
            if (mm_done) begin
               state_in = pt32_pkg::B_POW_SQR;
            end
         end
         pt32_pkg::B_POW_SQR: begin
            if (mm_done) begin
               state_in = pt32_pkg::B_POW_TEST;
            end
         end
         pt32_pkg::B_SQ_TEST: begin
            if (cnt_ff == '0) begin
               state_in = (y_ff != 32'd1 || last_base) ? pt32_pkg::B_FINISH
                                                      : pt32_pkg::B_MR_SPLIT;
            end else begin
               state_in = pt32_pkg::B_SQ_WAIT;
            end
         end
         pt32_pkg::B_SQ_WAIT: begin
            if (mm_done) begin
               state_in = witness ? pt32_pkg::B_FINISH : pt32_pkg::B_SQ_TEST;
            end
         end
         pt32_pkg::B_FINISH: begin
            if (out_free) begin
               state_in = pt32_pkg::B_IDLE;
            end
         end
         default: state_in = pt32_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop             = 1'b0;
      mm_req          = '0;
      n_in            = n_ff;
      cls_in          = cls_ff;
      div_in          = div_ff;
      sq_in           = sq_ff;
      side_in         = side_ff;
      e_in            = e_ff;
      s_in            = s_ff;
      cnt_in          = cnt_ff;
      acc_in          = acc_ff;
      b_in            = b_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      idx_in          = idx_ff;
      verdict_in      = verdict_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_prime_in = rsp_is_prime_ff;
      case (state_ff)
         pt32_pkg::B_IDLE: begin
            if (head_valid) begin
               pop        = 1'b1;
               n_in       = head.candidate;
               cls_in     = head.cls;
               verdict_in = (head.cls == pt32_pkg::CLS_PRIME);
               div_in     = pt32_pkg::FIRST_DIV;
               sq_in      = pt32_pkg::FIRST_SQ;
               side_in    = 1'b0;
               e_in       = head.candidate - 32'd1;
               s_in       = '0;
               idx_in     = '0;
            end
         end
         pt32_pkg::B_TD_TEST: begin
            if (sq_above) begin
               verdict_in = 1'b1;
            end else begin
               mm_req.start = 1'b1;
               mm_req.x     = 32'd1;
               mm_req.y     = n_ff;
               mm_req.m     = 32'(div_ff);
               side_in      = 1'b0;
            end
         end
         pt32_pkg::B_TD_WAIT: begin
            if (mm_done) begin
               if (mm_result == '0) begin
                  verdict_in = 1'b0;
               end else if (!side_ff) begin
                  side_in      = 1'b1;
                  mm_req.start = 1'b1;
                  mm_req.x     = 32'd1;
                  mm_req.y     = n_ff;
                  mm_req.m     = 32'(div_hi);
               end else begin
                  div_in = div_ff + DW'(6);
                  sq_in  = sq_ff + SW'({div_ff, 3'b000}) + SW'({div_ff, 2'b00}) + SW'(36);
               end
            end
         end
         pt32_pkg::B_MR_SPLIT: begin
            if (!e_ff[0]) begin
               e_in = {1'b0, e_ff[31:1]};
               s_in = s_ff + pt32_pkg::SHIFT_W'(1);
            end else begin
               acc_in = 32'd1;
               b_in   = pt32_pkg::base_of(cls_ff, idx_ff);
            end
         end
         pt32_pkg::B_POW_TEST: begin
            if (e_ff == '0) begin
               x_in   = acc_ff;
               y_in   = acc_ff;
               cnt_in = s_ff;
            end else begin
               mm_req.start = 1'b1;
               mm_req.x     = e_ff[0] ? acc_ff : b_ff;
               mm_req.y     = b_ff;
               mm_req.m     = n_ff;
            end
         end
         pt32_pkg::B_POW_MUL: begin
            if (mm_done) begin
               acc_in       = mm_result;
               mm_req.start = 1'b1;
               mm_req.x     = b_ff;
               mm_req.y     = b_ff;
               mm_req.m     = n_ff;
            end
         end
         pt32_pkg::B_POW_SQR: begin
            if (mm_done) begin
               b_in = mm_result;
               e_in = {1'b0, e_ff[31:1]};
            end
         end
         pt32_pkg::B_SQ_TEST: begin
            if (cnt_ff == '0) begin
               if (y_ff != 32'd1) begin
                  verdict_in = 1'b0;
               end else if (last_base) begin
                  verdict_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 2'd1;
                  e_in   = n_ff - 32'd1;
                  s_in   = '0;
               end
            end else begin
               mm_req.start = 1'b1;
               mm_req.x     = x_ff;
               mm_req.y     = x_ff;
               mm_req.m     = n_ff;
            end
         end
         pt32_pkg::B_SQ_WAIT: begin
            if (mm_done) begin
               y_in = mm_result;
               if (witness) begin
                  verdict_in = 1'b0;
               end else begin
                  x_in   = mm_result;
                  cnt_in = cnt_ff - pt32_pkg::SHIFT_W'(1);
               end
            end
         end
         pt32_pkg::B_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
            end
         end
         default: begin
            verdict_in = verdict_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pt32_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      cls_ff          <= cls_in;
      div_ff          <= div_in;
      sq_ff           <= sq_in;
      side_ff         <= side_in;
      e_ff            <= e_in;
      s_ff            <= s_in;
      cnt_ff          <= cnt_in;
      acc_ff          <= acc_in;
      b_ff            <= b_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      idx_ff          <= idx_in;
      verdict_ff      <= verdict_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

endmodule

/* rtl/prime_test_u32_unit.sv */
// Channel  | Ports                                    | Beat
// req      | req_valid, req_stall, req_candidate      | one 32-bit number
// rsp      | rsp_valid, rsp_stall, rsp_is_prime       | one prime flag
//
// Each modular multiply runs 32 shift-add steps from issue to done.
// Trial division tests one 6k-1/6k+1 divisor pair at a time; Miller-Rabin squares once per exponent bit,
// multiplies as well when the bit is set, then runs the final squarings for each base, over 2 or 3 bases.
// Trivial cases go from the queue through the engine's idle and finish states to a registered rsp_valid.
// Reset (synchronous) empties the queue and idles the engine.
// A stalled rsp beat holds; req is stalled only while the queue is full.
module prime_test_u32_unit #(
   parameter int unsigned QUEUE_DEPTH = pt32_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pt32_pkg::CAND_W-1:0] req_candidate,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_prime
);

   pt32_pkg::entry_type  entry;
   pt32_pkg::entry_type  head;
   pt32_pkg::mm_req_type mm_req;
   logic                 full, head_valid, pop, mm_done;
   logic [pt32_pkg::CAND_W-1:0] mm_result;

   assign req_stall = full;

   pt32_front u_front (
      .candidate (req_candidate),
      .entry     (entry)
   );

   pt32_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_data  (entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   pt32_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .req    (mm_req),
      .done   (mm_done),
      .result (mm_result)
   );

   pt32_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .mm_req       (mm_req),
      .mm_done      (mm_done),
      .mm_result    (mm_result),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime),
      .rsp_stall    (rsp_stall)
   );

endmodule

/* bench/prime_flag_checker.sv */
`timescale 1ns / 1ps

module prime_flag_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_candidate,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_is_prime,
   output int          mismatch_count,
   output int          flags_pending,
   output int          beats_checked,
   output int          primes_seen
);

   logic        flag_queue[$];
   logic [31:0] cand_queue[$];

   function automatic logic [31:0] mod_mul(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] m);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return 32'(p % {32'd0, m});
   endfunction

   function automatic logic [31:0] mod_pow(input logic [31:0] b, input logic [31:0] e,
                                           input logic [31:0] m);
      logic [31:0] acc;
      logic [31:0] sq;
      acc = 32'd1 % m;
      sq = b % m;
      while (e != 32'd0) begin
         if (e[0]) acc = mod_mul(acc, sq, m);
         sq = mod_mul(sq, sq, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic logic base_proves_composite(input logic [31:0] a, input logic [31:0] n);
      logic [31:0] d;
      logic [31:0] x;
      logic [31:0] y;
      int          s;
      d = n - 32'd1;
      s = 0;
      while (d != 32'd0 && d[0] == 1'b0) begin
         d = d >> 1;
         s++;
      end
      x = mod_pow(a, d, n);
      y = x;
      for (int i = 0; i < s; i++) begin
         y = mod_mul(x, x, n);
         if (y == 32'd1 && x != 32'd1 && x != n - 32'd1) return 1'b1;
         x = y;
      end
      return y != 32'd1;
   endfunction

   function automatic logic prime_flag_of(input logic [31:0] n);
      logic [63:0] dv;
      if (n < 32'd2) return 1'b0;
      if (n[0] == 1'b0) return n == 32'd2;
      if (n % 32'd3 == 32'd0) return n == 32'd3;
      if (n < pt32_pkg::TRIAL_LIMIT) begin
         dv = 64'd5;
         while (dv * dv <= {32'd0, n}) begin
            if ({32'd0, n} % dv == 64'd0 || {32'd0, n} % (dv + 64'd2) == 64'd0) return 1'b0;
            dv += 64'd6;
         end
         return 1'b1;
      end
      if (n < pt32_pkg::PAIR_LIMIT)
         return !base_proves_composite(32'd31, n) && !base_proves_composite(32'd73, n);
      return !base_proves_composite(32'd2, n) && !base_proves_composite(32'd7, n) &&
             !base_proves_composite(32'd61, n);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      beats_checked = 0;
      primes_seen = 0;
   end

   assign flags_pending = flag_queue.size();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            flag_queue = {flag_queue, prime_flag_of(req_candidate)};
            cand_queue = {cand_queue, req_candidate};
         end
         if (rsp_valid && !rsp_stall) begin
            if (flag_queue.size() == 0) begin
               report_mismatch($sformatf("result beat is_prime=%0b with nothing pending",
                                         rsp_is_prime));
            end else begin
               logic        want;
               logic [31:0] cand;
               want = flag_queue.pop_front();
               cand = cand_queue.pop_front();
               beats_checked++;
               if (want) primes_seen++;
               if (rsp_is_prime !== want)
                  report_mismatch($sformatf("candidate %0d: is_prime=%0b, predicted %0b",
                                            cand, rsp_is_prime, want));
            end
         end
      end
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_candidate;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_is_prime;
   int          mismatch_count;
   int          flags_pending;
   int          beats_checked;
   int          primes_seen;
   logic        long_hold;
   int          items_sent;

   prime_test_u32_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_candidate(req_candidate),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

   prime_flag_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_prime  (rsp_is_prime),
      .mismatch_count(mismatch_count),
      .flags_pending (flags_pending),
      .beats_checked (beats_checked),
      .primes_seen   (primes_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   task automatic send_candidate(input logic [31:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_candidate <= c;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic logic [31:0] random_candidate();
      logic [31:0] c;
      int          r;
      r = $urandom_range(0, 9);
      if (r < 5) c = $urandom_range(0, 100000);
      else if (r < 7) c = $urandom_range(100000, 1373660);
      else if (r < 8) c = $urandom_range(1373640, 9080200);
      else c = $urandom;
      if ($urandom_range(0, 3) != 0) c[0] = 1'b1;
      return c;
   endfunction

   // receiver: random short stalls, rare long ones, and one forced long hold-off
   initial begin
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 199) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(50, 200)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [31:0] directed[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_candidate = '0;
      long_hold = 1'b0;
      items_sent = 0;
      directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
                   32'd1373651, 32'd1373652, 32'd1373653, 32'd1373659,
                   32'd9080189, 32'd9080191, 32'd9080197, 32'd25326001,
                   32'd2147483647, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'd3215031751, 32'd4294967291, 32'hFFFF_FFFF};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_candidate(directed[i]);
      // hold the result side while quick beats pile up
      long_hold = 1'b1;
      for (int i = 0; i < 12; i++) send_candidate(32'(2 * $urandom_range(2, 1000000)));
      for (int i = 0; i < 254; i++) send_candidate(random_candidate());
      req_valid <= 1'b0;
      while (flags_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d candidates; checked %0d flags, %0d of them prime.",
               items_sent, beats_checked, primes_seen);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #200ms;
      $display("Timeout with %0d flags pending", flags_pending);
      $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
rtl/pt32_pkg.sv
rtl/pt32_front.sv
rtl/pt32_queue.sv
rtl/pt32_modmul.sv
rtl/pt32_back.sv
rtl/prime_test_u32_unit.sv
bench/prime_flag_checker.sv
bench/tb_top.sv
